### sv/sbc_pkg.sv
package sbc_pkg;

  localparam int CoordWidthDef = 32;
  localparam int FracBitsDef   = 16;
  localparam int ClipRounds    = 6;
  localparam int NumRegs       = 6;
  localparam int RegIdxWidth   = 3;

  localparam logic [RegIdxWidth-1:0] RegMinX = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegMinY = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegMinZ = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegMaxX = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegMaxY = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegMaxZ = 3'd5;

  localparam logic [5:0] OcTop    = 6'b000001;
  localparam logic [5:0] OcBottom = 6'b000010;
  localparam logic [5:0] OcRight  = 6'b000100;
  localparam logic [5:0] OcLeft   = 6'b001000;
  localparam logic [5:0] OcFront  = 6'b010000;
  localparam logic [5:0] OcBack   = 6'b100000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the input word and compute both outcodes
    logic setup;      // pick the plane and load the first interpolation
    logic mul;        // register the product for the current interpolation
    logic div_start;  // start the serial divide
    logic store;      // store the finished coordinate, move to the second one
    logic commit;     // write the new point into the moving endpoint
    logic finish;     // write the result register
    logic accept;     // result is an accepted segment
  } sbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic both_in;    // both outcodes clear
    logic trivial_out;// outcodes share a bit
    logic div_done;
    logic second;     // the second free coordinate is in work
  } sbc_stat_t;

endpackage

### sv/sbc_ctrl.sv
module sbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              res_free_i,
  input  sbc_pkg::sbc_stat_t stat_i,
  output sbc_pkg::sbc_cmd_t  cmd_o
);
  import sbc_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StTest  = 7'b0000010,
    StSetup = 7'b0000100,
    StMul   = 7'b0001000,
    StDivGo = 7'b0010000,
    StDiv   = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] round_q, round_d;
  logic accept_q, accept_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d  = state_q;
    round_d  = round_q;
    accept_d = accept_q;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          round_d    = '0;
          state_d    = StTest;
        end
      end
      StTest: begin
        if (stat_i.both_in) begin
          accept_d = 1'b1;
          state_d  = StDone;
        end else if (stat_i.trivial_out || round_q == 3'(ClipRounds)) begin
          accept_d = 1'b0;
          state_d  = StDone;
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = StMul;
        end
      end
      StSetup: begin
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDivGo;
      end
      StDivGo: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        if (stat_i.div_done) begin
          cmd_o.store = 1'b1;
          if (stat_i.second) begin
            cmd_o.commit = 1'b1;
            round_d      = round_q + 3'd1;
            state_d      = StTest;
          end else begin
            state_d = StMul;
          end
        end
      end
      StDone: begin
        if (res_free_i) begin
          cmd_o.finish = 1'b1;
          cmd_o.accept = accept_q;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      round_q  <= '0;
      accept_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      round_q  <= round_d;
      accept_q <= accept_d;
    end
  end

endmodule

### sv/sbc_div.sv
// Restoring divider, one quotient bit per cycle. The quotient saturates at
// 2^(NW-2) once it reaches it.
module sbc_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d, quot_q, quot_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, sat_q, sat_d;
  logic [DW:0]   shifted;
  logic          qb;

  assign shifted = {rem_q[DW-1:0], num_q[NW-1]};
  assign qb      = shifted >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sat_d  = sat_q;
    if (start_i) begin
      num_d  = num_i;
      quot_d = '0;
      rem_d  = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      rem_d = qb ? shifted - {1'b0, den_q} : shifted;
      if (!sat_q) begin
        quot_d = {quot_q[NW-2:0], qb};
        if (quot_d[NW-1] || quot_d[NW-2]) sat_d = 1'b1;
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) den_q <= den_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0; quot_q <= '0; rem_q <= '0; cnt_q <= '0;
      busy_q <= 1'b0; sat_q <= 1'b0;
    end else begin
      num_q <= num_d; quot_q <= quot_d; rem_q <= rem_d; cnt_q <= cnt_d;
      busy_q <= busy_d; sat_q <= sat_d;
    end
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quot_o = sat_d ? {2'b01, {(NW-2){1'b0}}} : quot_d;

endmodule

### sv/sbc_dp.sv
module sbc_dp #(
  parameter int CoordWidth = sbc_pkg::CoordWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [6*CoordWidth-1:0]   box_i,
  input  logic [6*CoordWidth-1:0]   seg_i,
  input  sbc_pkg::sbc_cmd_t         cmd_i,
  output sbc_pkg::sbc_stat_t        stat_o,
  output logic [6*CoordWidth-1:0]   clip_o
);
  import sbc_pkg::*;

  localparam int W  = CoordWidth;
  localparam int EW = W + 1;       // difference width
  localparam int PW = 2 * W;       // product magnitude width
  localparam int NW = PW + 2;      // quotient register width

  logic signed [W-1:0] o_q [3];
  logic signed [W-1:0] e_q [3];
  logic signed [W-1:0] p0_q [3];
  logic signed [W-1:0] p1_q [3];
  logic signed [W-1:0] np_q [3];
  logic signed [W-1:0] bmin [3];
  logic signed [W-1:0] bmax [3];
  logic [5:0] c0_q, c1_q;
  logic [1:0] axis_q;              // plane axis: 0 x, 1 y, 2 z
  logic [1:0] free_q [2];
  logic signed [W-1:0] plane_q;
  logic sel_q, which_q;
  logic [PW-1:0] prod_q;
  logic neg_q, zero_q;
  logic [NW-1:0] quot;
  logic div_done;

  for (genvar k = 0; k < 3; k++) begin : g_box
    assign bmin[k] = box_i[k*W +: W];
    assign bmax[k] = box_i[(k+3)*W +: W];
  end

  function automatic logic [5:0] outc(input logic signed [W-1:0] x,
    input logic signed [W-1:0] y, input logic signed [W-1:0] z,
    input logic signed [W-1:0] mnx, input logic signed [W-1:0] mny,
    input logic signed [W-1:0] mnz, input logic signed [W-1:0] mxx,
    input logic signed [W-1:0] mxy, input logic signed [W-1:0] mxz);
    logic [5:0] c;
    c = '0;
    if (y > mxy) c |= OcTop; else if (y < mny) c |= OcBottom;
    if (x > mxx) c |= OcRight; else if (x < mnx) c |= OcLeft;
    if (z < mnz) c |= OcFront; else if (z > mxz) c |= OcBack;
    return c;
  endfunction

  // Plane choice from the outcode of the moving endpoint.
  logic [5:0] cs;
  logic [1:0] ax;
  logic [1:0] fa0, fa1;
  logic signed [W-1:0] pl;
  assign cs = (c0_q != '0) ? c0_q : c1_q;
  always_comb begin
    if ((cs & (OcTop | OcBottom)) != '0) begin
      ax = 2'd1; fa0 = 2'd0; fa1 = 2'd2;
      pl = ((cs & OcTop) != '0) ? bmax[1] : bmin[1];
    end else if ((cs & (OcRight | OcLeft)) != '0) begin
      ax = 2'd0; fa0 = 2'd1; fa1 = 2'd2;
      pl = ((cs & OcRight) != '0) ? bmax[0] : bmin[0];
    end else begin
      ax = 2'd2; fa0 = 2'd0; fa1 = 2'd1;
      pl = ((cs & OcFront) != '0) ? bmin[2] : bmax[2];
    end
  end

  // Differences for the current free coordinate.
  logic [1:0] fa;
  logic signed [EW-1:0] d, n, den;
  logic [W-1:0] md, mn, mden;
  assign fa  = free_q[which_q];
  assign d   = EW'(e_q[fa]) - EW'(o_q[fa]);
  assign n   = EW'(plane_q) - EW'(o_q[axis_q]);
  assign den = EW'(e_q[axis_q]) - EW'(o_q[axis_q]);
  assign md  = W'(d[EW-1] ? -d : d);
  assign mn  = W'(n[EW-1] ? -n : n);
  assign mden = W'(den[EW-1] ? -den : den);

  sbc_div #(.NW(NW), .DW(W)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i  (NW'(prod_q)),
    .den_i  (mden),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Final add and saturation.
  localparam int SW = NW + 2;
  localparam logic signed [SW-1:0] SumMax = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SumMin = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  logic signed [SW-1:0] sum;
  logic signed [W-1:0]  res;
  assign sum = neg_q ? SW'(o_q[fa]) - SW'(quot) : SW'(o_q[fa]) + SW'(quot);
  always_comb begin
    if (zero_q) res = o_q[fa];
    else if (sum > SumMax) res = {1'b0, {(W-1){1'b1}}};
    else if (sum < SumMin) res = {1'b1, {(W-1){1'b0}}};
    else res = W'(sum);
  end

  logic signed [W-1:0] nx, ny, nz;
  always_comb begin
    nx = np_q[0]; ny = np_q[1]; nz = np_q[2];
    case (fa)
      2'd0: nx = res;
      2'd1: ny = res;
      default: nz = res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 3; k++) begin
        o_q[k]  <= seg_i[k*W +: W];
        e_q[k]  <= seg_i[(k+3)*W +: W];
        p0_q[k] <= seg_i[k*W +: W];
        p1_q[k] <= seg_i[(k+3)*W +: W];
      end
      c0_q <= outc(seg_i[0 +: W], seg_i[W +: W], seg_i[2*W +: W],
                   bmin[0], bmin[1], bmin[2], bmax[0], bmax[1], bmax[2]);
      c1_q <= outc(seg_i[3*W +: W], seg_i[4*W +: W], seg_i[5*W +: W],
                   bmin[0], bmin[1], bmin[2], bmax[0], bmax[1], bmax[2]);
    end
    if (cmd_i.setup) begin
      axis_q    <= ax;
      free_q[0] <= fa0;
      free_q[1] <= fa1;
      plane_q   <= pl;
      which_q   <= 1'b0;
      sel_q     <= (c0_q != '0);
      np_q[ax]  <= pl;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(md) * PW'(mn);
      neg_q  <= (d[EW-1] ^ n[EW-1]) ^ den[EW-1];
      zero_q <= (d == '0) || (n == '0) || (den == '0);
    end
    if (cmd_i.store) begin
      np_q[fa] <= res;
      which_q  <= 1'b1;
    end
    if (cmd_i.commit) begin
      if (sel_q) begin
        p0_q[0] <= nx; p0_q[1] <= ny; p0_q[2] <= nz;
        c0_q <= outc(nx, ny, nz, bmin[0], bmin[1], bmin[2],
                     bmax[0], bmax[1], bmax[2]);
      end else begin
        p1_q[0] <= nx; p1_q[1] <= ny; p1_q[2] <= nz;
        c1_q <= outc(nx, ny, nz, bmin[0], bmin[1], bmin[2],
                     bmax[0], bmax[1], bmax[2]);
      end
    end
  end

  assign stat_o.both_in     = (c0_q | c1_q) == '0;
  assign stat_o.trivial_out = (c0_q & c1_q) != '0;
  assign stat_o.div_done    = div_done;
  assign stat_o.second      = which_q;

  for (genvar k = 0; k < 3; k++) begin : g_out
    assign clip_o[k*W +: W]     = p0_q[k];
    assign clip_o[(k+3)*W +: W] = p1_q[k];
  end

endmodule

### sv/segment_box_clipper_3d_top.sv
// Clips a 3D segment against the box held in the six corner registers using
// Cohen-Sutherland rounds. One word is taken at a time. Each clip round runs
// two interpolations, each a registered multiply and a restoring divide of one
// quotient bit per cycle over 2*COORD_WIDTH+2 bits. A word runs up to six
// rounds. The result sits in an output register, so a new word may enter
// while it waits. Coordinates are signed fixed point; FRAC_BITS only sets
// their scale.
module segment_box_clipper_3d_top #(
  parameter int COORD_WIDTH = sbc_pkg::CoordWidthDef,
  parameter int FRAC_BITS   = sbc_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sbc_pkg::RegIdxWidth-1:0]   cfg_index_i,
  input  logic [COORD_WIDTH-1:0]            cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [(6*COORD_WIDTH+7)/8*8-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // clip_start_x, clip_start_y, clip_start_z, clip_end_x, clip_end_y, clip_end_z
  output logic [(6*COORD_WIDTH+7)/8*8-1:0]  m_axis_tdata,
  // accepted
  output logic                              m_axis_tuser
);
  import sbc_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int DataW = (6*W+7)/8*8;
  localparam int FracScale = FRAC_BITS;  // scale only, no arithmetic effect

  logic [W-1:0] box_q [6];
  logic [6*W-1:0] box;
  sbc_cmd_t  cmd;
  sbc_stat_t stat;
  logic [6*W-1:0] clip;
  logic out_valid_q;
  logic [6*W-1:0] out_data_q;
  logic out_acc_q;
  logic res_free;

  assign cfg_ready_o = (FracScale >= 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) box_q[k] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMinX: box_q[0] <= cfg_data_i;
        RegMinY: box_q[1] <= cfg_data_i;
        RegMinZ: box_q[2] <= cfg_data_i;
        RegMaxX: box_q[3] <= cfg_data_i;
        RegMaxY: box_q[4] <= cfg_data_i;
        RegMaxZ: box_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_box
    assign box[k*W +: W] = box_q[k];
  end

  assign res_free = !out_valid_q || m_axis_tready;

  sbc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .res_free_i(res_free),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sbc_dp #(.CoordWidth(W)) u_dp (
    .clk_i, .rst_ni,
    .box_i (box),
    .seg_i (s_axis_tdata[6*W-1:0]),
    .cmd_i (cmd),
    .stat_o(stat),
    .clip_o(clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      out_acc_q  <= cmd.accept;
      out_data_q <= cmd.accept ? clip : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_acc_q;
  assign m_axis_tdata  = DataW'(out_data_q);

  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("rejected word carries nonzero data");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> res_free)
    else $error("result written over a pending word");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule
